// ===== hw/rtl/clkcal_pkg.sv =====
// ============================================================================
// clkcal_pkg: shared types and helpers for the clock/calendar core
// Item kinds, cursor columns, field widths, reset values and small
// calendar helper functions.
// ============================================================================
package clkcal_pkg;

   // Field widths
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned CURSOR_W  = 4;
   localparam int unsigned SEC_W     = 6;
   localparam int unsigned MIN_W     = 6;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned YEAR_W    = 7;
   localparam int unsigned TPS_W     = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_DAT_W = 8;
   localparam int unsigned RSP_DAT_W = 40;

   // Reset values
   localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd1000;
   localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
   localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;

   // Item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK      = 3'd0,
      KIND_DATE_UP   = 3'd1,
      KIND_DATE_DOWN = 3'd2,
      KIND_TIME_UP   = 3'd3,
      KIND_TIME_DOWN = 3'd4
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RUN_ENABLE = 1'd0,
      CSR_TICKS_PER_SEC = 1'd1
   } csr_index_type;

   // Cursor columns: tens/ones of the first, second and third digit pair
   localparam logic [CURSOR_W-1:0] COL_PAIR1_TENS = 4'd8;
   localparam logic [CURSOR_W-1:0] COL_PAIR1_ONES = 4'd9;
   localparam logic [CURSOR_W-1:0] COL_PAIR2_TENS = 4'd11;
   localparam logic [CURSOR_W-1:0] COL_PAIR2_ONES = 4'd12;
   localparam logic [CURSOR_W-1:0] COL_PAIR3_TENS = 4'd14;
   localparam logic [CURSOR_W-1:0] COL_PAIR3_ONES = 4'd15;

   // April, June, September, November
   function automatic logic is_short_month(input logic [MONTH_W-1:0] m);
      return (m == 4'd4) || (m == 4'd6) || (m == 4'd9) || (m == 4'd11);
   endfunction

   // True when the low decimal digit of v equals dgt (v below 130)
   function automatic logic ones_is(input logic [6:0] v, input logic [3:0] dgt);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 13; k++) begin
         if ({1'b0, v} == (8'(k * 10) + {4'b0000, dgt})) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

// ===== hw/rtl/clock_calendar_with_digit_edit_core.sv =====
// ============================================================================
// clock_calendar_with_digit_edit_core: real-time clock and calendar
// Tick prescaler, second-to-year carry chain over a two-digit year, and
// per-digit up/down editing of date and time at a cursor column.
// ============================================================================
// The core takes one beat per clock cycle unless a held response stalls it:
// each accepted request beat updates the clock state and loads the response
// register in that same cycle, so the response is registered and a new
// request can follow every cycle; there is a single state/response register
// stage. req_tready stays high while the response register is empty or being
// drained, so a stalled response blocks new requests only while it is held.
// Every request beat (tick, edit or unknown kind) yields exactly one response
// beat with the clock and date after the beat. CSR writes (run enable,
// ticks per second) are meant to be made while the core is idle.
module clock_calendar_with_digit_edit_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] cursor_position, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [5:0] seconds_now, [11:6] minutes_now,
                                    // [16:12] hours_now, [21:17] day_now,
                                    // [25:22] month_now, [32:26] year_now,
                                    // [39:33] zero
   output logic [0:0]  rsp_tuser,   // [0] second_stepped
   // configuration write port
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------------
   logic                                  run_enable_ff;
   logic [clkcal_pkg::TPS_W-1:0]          tps_ff;
   logic [clkcal_pkg::TPS_W-1:0]          prescale_ff, prescale_in;
   logic [clkcal_pkg::SEC_W-1:0]          sec_ff, sec_in;
   logic [clkcal_pkg::MIN_W-1:0]          min_ff, min_in;
   logic [clkcal_pkg::HOUR_W-1:0]         hour_ff, hour_in;
   logic [clkcal_pkg::DAY_W-1:0]          day_ff, day_in;
   logic [clkcal_pkg::MONTH_W-1:0]        month_ff, month_in;
   logic [clkcal_pkg::YEAR_W-1:0]         year_ff, year_in;
   logic                                  stepped_in;

   logic                                  rsp_valid_ff;
   logic [clkcal_pkg::RSP_DAT_W-1:0]      rsp_data_ff;
   logic                                  rsp_stepped_ff;

   logic                                  req_beat;
   clkcal_pkg::kind_type                  kind;
   logic [clkcal_pkg::CURSOR_W-1:0]       cursor;
   logic                                  leap;
   logic                                  leap_locked;

   // tick path
   logic [clkcal_pkg::TPS_W:0]            pre_next;
   logic [clkcal_pkg::TPS_W:0]            pre_limit;
   logic [6:0]                            s_t, m_t;
   logic [5:0]                            h_t, d_t;
   logic [4:0]                            mo_t;
   logic [7:0]                            y_t;

   assign req_beat = req_tvalid && req_tready;
   assign kind     = clkcal_pkg::kind_type'(req_tuser);
   assign cursor   = req_tdata[clkcal_pkg::CURSOR_W-1:0];
   assign leap     = (year_ff[1:0] == 2'b00);
   assign leap_locked = (month_ff == 4'd2) && (day_ff == 5'd29) && leap;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff <= 1'b1;
         tps_ff        <= clkcal_pkg::TPS_RESET;
      end else if (csr_we) begin
         unique case (clkcal_pkg::csr_index_type'(csr_index))
            clkcal_pkg::CSR_RUN_ENABLE:    run_enable_ff <= csr_wdata[0];
            clkcal_pkg::CSR_TICKS_PER_SEC: tps_ff <= csr_wdata[clkcal_pkg::TPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Tick path: prescaler and second-to-year carry chain
   // ---------------------------------------------------------------------
   always_comb begin
      pre_next  = {1'b0, prescale_ff} + 17'd1;
      pre_limit = (tps_ff == '0) ? 17'd1 : {1'b0, tps_ff};

      s_t  = {1'b0, sec_ff} + 7'd1;
      m_t  = {1'b0, min_ff};
      h_t  = {1'b0, hour_ff};
      d_t  = {1'b0, day_ff};
      mo_t = {1'b0, month_ff};
      y_t  = {1'b0, year_ff};
      if (s_t == 7'd60) begin
         s_t = '0;
         m_t = m_t + 7'd1;
      end
      if (m_t == 7'd60) begin
         m_t = '0;
         h_t = h_t + 6'd1;
      end
      if (h_t == 6'd24) begin
         h_t = '0;
         d_t = d_t + 6'd1;
      end
      if ((d_t == 6'd31 && clkcal_pkg::is_short_month(month_ff)) ||
          (d_t == 6'd29 && month_ff == 4'd2 && !leap) ||
          (d_t == 6'd30 && month_ff == 4'd2 && leap) ||
          (d_t == 6'd32)) begin
         d_t  = 6'd1;
         mo_t = mo_t + 5'd1;
      end
      if (mo_t == 5'd13) begin
         mo_t = 5'd1;
         y_t  = y_t + 8'd1;
      end
      if (y_t == 8'd100) y_t = '0;
   end

   // ---------------------------------------------------------------------
   // Next state for one request beat
   // ---------------------------------------------------------------------
   always_comb begin
      prescale_in = prescale_ff;
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      stepped_in  = 1'b0;

      case (kind)
         clkcal_pkg::KIND_TICK: begin
            if (run_enable_ff) begin
               if (pre_next >= pre_limit) begin
                  prescale_in = '0;
                  sec_in      = s_t[clkcal_pkg::SEC_W-1:0];
                  min_in      = m_t[clkcal_pkg::MIN_W-1:0];
                  hour_in     = h_t[clkcal_pkg::HOUR_W-1:0];
                  day_in      = d_t[clkcal_pkg::DAY_W-1:0];
                  month_in    = mo_t[clkcal_pkg::MONTH_W-1:0];
                  year_in     = y_t[clkcal_pkg::YEAR_W-1:0];
                  stepped_in  = 1'b1;
               end else begin
                  prescale_in = pre_next[clkcal_pkg::TPS_W-1:0];
               end
            end
         end

         clkcal_pkg::KIND_DATE_UP: begin
            case (cursor)
               clkcal_pkg::COL_PAIR1_TENS: begin
                  if (day_ff == 5'd21 && clkcal_pkg::is_short_month(month_ff))
                     day_in = 5'd1;
                  else if (day_ff == 5'd20 && month_ff == 4'd2) day_in = 5'd10;
                  else if (day_ff == 5'd21 && month_ff == 4'd2) day_in = 5'd11;
                  else if (day_ff == 5'd19 && month_ff == 4'd2 && !leap) day_in = 5'd9;
                  else if (day_ff > 5'd30) day_in = day_ff - 5'd30;
                  else if (day_ff == 5'd30) day_in = 5'd10;
                  else if (day_ff >= 5'd22) day_in = day_ff - 5'd20;
                  else day_in = day_ff + 5'd10;
               end
               clkcal_pkg::COL_PAIR1_ONES: begin
                  if (day_ff == 5'd29 && month_ff == 4'd2 && leap) day_in = 5'd20;
                  else if (day_ff == 5'd28 && month_ff == 4'd2 && !leap) day_in = 5'd20;
                  else if (day_ff == 5'd30 && clkcal_pkg::is_short_month(month_ff)) ;
                  else if (day_ff == 5'd31) day_in = 5'd30;
                  else if (day_ff == 5'd9) day_in = 5'd1;
                  else if (clkcal_pkg::ones_is({2'b00, day_ff}, 4'd9))
                     day_in = day_ff - 5'd9;
                  else day_in = day_ff + 5'd1;
               end
               clkcal_pkg::COL_PAIR2_TENS: begin
                  // month tens toggle, guarded on January 31st
                  if (day_ff == 5'd31 && month_ff == 4'd1) ;
                  else if (month_ff <= 4'd2) month_in = month_ff + 4'd10;
                  else if (month_ff == 4'd10) month_in = 4'd1;
                  else if (month_ff > 4'd10) month_in = month_ff - 4'd10;
               end
               clkcal_pkg::COL_PAIR2_ONES: begin
                  if (day_ff == 5'd31 && month_ff != 4'd7) ;
                  else if (day_ff > 5'd28 && month_ff == 4'd1 && !leap) ;
                  else if (day_ff > 5'd29 && month_ff == 4'd1 && leap) ;
                  else if (month_ff == 4'd12) month_in = 4'd10;
                  else if (month_ff == 4'd9) month_in = 4'd1;
                  else month_in = month_ff + 4'd1;
               end
               clkcal_pkg::COL_PAIR3_TENS: begin
                  if (leap_locked) ;
                  else if (year_ff >= 7'd90) year_in = year_ff - 7'd90;
                  else year_in = year_ff + 7'd10;
               end
               clkcal_pkg::COL_PAIR3_ONES: begin
                  if (leap_locked) ;
                  else if (clkcal_pkg::ones_is(year_ff, 4'd9)) year_in = year_ff - 7'd9;
                  else year_in = year_ff + 7'd1;
               end
               default: ;
            endcase
         end

         clkcal_pkg::KIND_DATE_DOWN: begin
            case (cursor)
               clkcal_pkg::COL_PAIR1_TENS: begin
                  if (day_ff == 5'd1 &&
                      (month_ff == 4'd2 || clkcal_pkg::is_short_month(month_ff)))
                     day_in = 5'd21;
                  else if (day_ff == 5'd9 && month_ff == 4'd2 && !leap) day_in = 5'd19;
                  else if (day_ff <= 5'd1) day_in = day_ff + 5'd30;
                  else if (day_ff < 5'd10) day_in = day_ff + 5'd20;
                  else if (day_ff == 5'd10 && month_ff == 4'd2) day_in = 5'd20;
                  else if (day_ff == 5'd10) day_in = 5'd30;
                  else day_in = day_ff - 5'd10;
               end
               clkcal_pkg::COL_PAIR1_ONES: begin
                  if (day_ff == 5'd20 && month_ff == 4'd2 && !leap) day_in = 5'd28;
                  else if (day_ff == 5'd30 && clkcal_pkg::is_short_month(month_ff)) ;
                  else if (day_ff == 5'd30) day_in = 5'd31;
                  else if (day_ff == 5'd1) day_in = 5'd9;
                  else if (clkcal_pkg::ones_is({2'b00, day_ff}, 4'd0))
                     day_in = day_ff + 5'd9;
                  else day_in = day_ff - 5'd1;
               end
               clkcal_pkg::COL_PAIR2_TENS: begin
                  if (day_ff == 5'd31 && month_ff == 4'd1) ;
                  else if (month_ff <= 4'd2) month_in = month_ff + 4'd10;
                  else if (month_ff == 4'd10) month_in = 4'd1;
                  else if (month_ff > 4'd10) month_in = month_ff - 4'd10;
               end
               clkcal_pkg::COL_PAIR2_ONES: begin
                  if (day_ff == 5'd31 && month_ff != 4'd8) ;
                  else if (day_ff > 5'd28 && month_ff == 4'd3 && !leap) ;
                  else if (day_ff > 5'd29 && month_ff == 4'd3 && leap) ;
                  else if (month_ff == 4'd10) month_in = 4'd12;
                  else if (month_ff == 4'd1) month_in = 4'd9;
                  else month_in = month_ff - 4'd1;
               end
               clkcal_pkg::COL_PAIR3_TENS: begin
                  if (leap_locked) ;
                  else if (year_ff < 7'd10) year_in = year_ff + 7'd90;
                  else year_in = year_ff - 7'd10;
               end
               clkcal_pkg::COL_PAIR3_ONES: begin
                  if (leap_locked) ;
                  else if (clkcal_pkg::ones_is(year_ff, 4'd0)) year_in = year_ff + 7'd9;
                  else year_in = year_ff - 7'd1;
               end
               default: ;
            endcase
         end

         clkcal_pkg::KIND_TIME_UP: begin
            case (cursor)
               clkcal_pkg::COL_PAIR1_TENS: begin
                  if (hour_ff >= 5'd20) hour_in = hour_ff - 5'd20;
                  else if (hour_ff > 5'd13) hour_in = hour_ff - 5'd10;
                  else hour_in = hour_ff + 5'd10;
               end
               clkcal_pkg::COL_PAIR1_ONES: begin
                  if (hour_ff == 5'd23) hour_in = 5'd20;
                  else if (clkcal_pkg::ones_is({2'b00, hour_ff}, 4'd9))
                     hour_in = hour_ff - 5'd9;
                  else hour_in = hour_ff + 5'd1;
               end
               clkcal_pkg::COL_PAIR2_TENS: begin
                  if (min_ff >= 6'd50) min_in = min_ff - 6'd50;
                  else min_in = min_ff + 6'd10;
               end
               clkcal_pkg::COL_PAIR2_ONES: begin
                  if (clkcal_pkg::ones_is({1'b0, min_ff}, 4'd9)) min_in = min_ff - 6'd9;
                  else min_in = min_ff + 6'd1;
               end
               clkcal_pkg::COL_PAIR3_TENS: begin
                  if (sec_ff >= 6'd50) sec_in = sec_ff - 6'd50;
                  else sec_in = sec_ff + 6'd10;
               end
               clkcal_pkg::COL_PAIR3_ONES: begin
                  if (clkcal_pkg::ones_is({1'b0, sec_ff}, 4'd9)) sec_in = sec_ff - 6'd9;
                  else sec_in = sec_ff + 6'd1;
               end
               default: ;
            endcase
         end

         clkcal_pkg::KIND_TIME_DOWN: begin
            case (cursor)
               clkcal_pkg::COL_PAIR1_TENS: begin
                  if (hour_ff < 5'd10)
                     hour_in = hour_ff + ((hour_ff >= 5'd4) ? 5'd10 : 5'd20);
                  else hour_in = hour_ff - 5'd10;
               end
               clkcal_pkg::COL_PAIR1_ONES: begin
                  if (hour_ff == 5'd20) hour_in = 5'd23;
                  else if (clkcal_pkg::ones_is({2'b00, hour_ff}, 4'd0))
                     hour_in = hour_ff + 5'd9;
                  else hour_in = hour_ff - 5'd1;
               end
               clkcal_pkg::COL_PAIR2_TENS: begin
                  if (min_ff < 6'd10) min_in = min_ff + 6'd50;
                  else min_in = min_ff - 6'd10;
               end
               clkcal_pkg::COL_PAIR2_ONES: begin
                  if (clkcal_pkg::ones_is({1'b0, min_ff}, 4'd0)) min_in = min_ff + 6'd9;
                  else min_in = min_ff - 6'd1;
               end
               clkcal_pkg::COL_PAIR3_TENS: begin
                  if (sec_ff < 6'd10) sec_in = sec_ff + 6'd50;
                  else sec_in = sec_ff - 6'd10;
               end
               clkcal_pkg::COL_PAIR3_ONES: begin
                  if (clkcal_pkg::ones_is({1'b0, sec_ff}, 4'd0)) sec_in = sec_ff + 6'd9;
                  else sec_in = sec_ff - 6'd1;
               end
               default: ;
            endcase
         end

         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Clock state registers, updated on each request beat
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         sec_ff      <= '0;
         min_ff      <= '0;
         hour_ff     <= '0;
         day_ff      <= clkcal_pkg::DAY_RESET;
         month_ff    <= clkcal_pkg::MONTH_RESET;
         year_ff     <= '0;
      end else if (req_beat) begin
         prescale_ff <= prescale_in;
         sec_ff      <= sec_in;
         min_ff      <= min_in;
         hour_ff     <= hour_in;
         day_ff      <= day_in;
         month_ff    <= month_in;
         year_ff     <= year_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff    <= {7'd0, year_in, month_in, day_in, hour_in, min_in, sec_in};
         rsp_stepped_ff <= stepped_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stepped_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
   // clock state holds between request beats, CSR writes included
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_beat |=> $stable({sec_ff, min_ff, hour_ff, day_ff, month_ff, year_ff}))
      else $error("clock state changed without a request beat");

   // only a tick can report a second step
   a_step_tick_only: assert property (@(posedge clock) disable iff (reset)
      (req_beat && kind != clkcal_pkg::KIND_TICK) |=> !rsp_tuser[0])
      else $error("second_stepped set for a non-tick beat");

   // a paused clock never steps
   a_paused: assert property (@(posedge clock) disable iff (reset)
      (req_beat && !run_enable_ff) |=> (!rsp_tuser[0] && $stable(prescale_ff)))
      else $error("paused clock advanced");

   // calendar fields stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      (sec_ff < 6'd60) && (min_ff < 6'd60) && (hour_ff < 5'd24) &&
      (day_ff != 5'd0) && (month_ff != 4'd0) && (month_ff < 4'd13) &&
      (year_ff < 7'd100))
      else $error("clock field out of range");

   // a held response blocks new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");
`endif

endmodule

// ===== bench/clock_calendar_with_digit_edit_core_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// clock_calendar_with_digit_edit_core_test: self-checking bench for the core
// A scripted opening covers reset values, unknown kinds and columns, the
// prescaler corner cases, a paused clock and a full year rollover. Random
// rounds then retune the registers, steer the clock toward month and year
// ends with digit edits and tick through the carries, mixed with noise.
// Every response beat is checked against an in-bench calendar model or a scripted reading.
// ============================================================================
module clock_calendar_with_digit_edit_core_test;

   localparam int ITEM_COUNT  = 1950;
   localparam int QUIET_ITEMS = 300;    // no idling over the last stretch
   localparam int HOLD_AFTER  = 600;    // beat count that starts the long stall
   localparam int HOLD_CYCLES = 150;
   localparam int CYCLE_LIMIT = 200000;

   // codes outside the defined set
   localparam logic [clkcal_pkg::KIND_W-1:0]   KIND_SPARE_LO = 3'd5;
   localparam logic [clkcal_pkg::KIND_W-1:0]   KIND_SPARE_HI = 3'd7;
   localparam logic [clkcal_pkg::CURSOR_W-1:0] COL_NONE      = 4'd0;
   localparam logic [clkcal_pkg::CURSOR_W-1:0] COL_GAP       = 4'd13;

   typedef struct packed {
      logic [clkcal_pkg::TPS_W-1:0]   prescale;
      logic [clkcal_pkg::SEC_W-1:0]   sec;
      logic [clkcal_pkg::MIN_W-1:0]   mins;
      logic [clkcal_pkg::HOUR_W-1:0]  hour;
      logic [clkcal_pkg::DAY_W-1:0]   day;
      logic [clkcal_pkg::MONTH_W-1:0] mon;
      logic [clkcal_pkg::YEAR_W-1:0]  yr;
   } cal_state_type;

   typedef struct packed {
      logic [clkcal_pkg::SEC_W-1:0]   sec;
      logic [clkcal_pkg::MIN_W-1:0]   mins;
      logic [clkcal_pkg::HOUR_W-1:0]  hour;
      logic [clkcal_pkg::DAY_W-1:0]   day;
      logic [clkcal_pkg::MONTH_W-1:0] mon;
      logic [clkcal_pkg::YEAR_W-1:0]  yr;
      logic                           stepped;
   } cal_reading_type;

   typedef enum logic [1:0] {ROW_BEAT, ROW_CHECKED, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type                 op;
      logic [2:0]                 kind;
      logic [3:0]                 col;
      clkcal_pkg::csr_index_type  idx;
      logic [15:0]                val;
      cal_reading_type            want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // calendar model and its register copies
   cal_state_type   cal;
   logic            run_cfg;
   logic [15:0]     rate_cfg;
   cal_reading_type readings_due[$];

   // typed expectation carried alongside the beat on the bus
   logic            beat_has_want = 1'b0;
   cal_reading_type beat_want = '0;

   int  mismatches = 0;
   int  items_sent = 0;
   int  cycles = 0;
   logic quiet = 1'b0;
   logic hold_req = 1'b0;

   logic [3:0] edit_cols [6] = '{clkcal_pkg::COL_PAIR1_TENS, clkcal_pkg::COL_PAIR1_ONES,
                                 clkcal_pkg::COL_PAIR2_TENS, clkcal_pkg::COL_PAIR2_ONES,
                                 clkcal_pkg::COL_PAIR3_TENS, clkcal_pkg::COL_PAIR3_ONES};

   script_row_type script[$];

   clock_calendar_with_digit_edit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one beat to the calendar model; returns the reading after it
   function automatic cal_reading_type next_reading(logic [2:0] kind, logic [3:0] col);
      int s, mi, h, d, m, y, lim, nxt;
      logic leap, short_m, stepped, date_edit;
      cal_reading_type r;
      s = cal.sec; mi = cal.mins; h = cal.hour;
      d = cal.day; m = cal.mon;   y = cal.yr;
      leap = (y % 4 == 0);
      short_m = (m == 4) || (m == 6) || (m == 9) || (m == 11);
      date_edit = (kind == clkcal_pkg::KIND_DATE_UP) || (kind == clkcal_pkg::KIND_DATE_DOWN);
      stepped = 1'b0;
      if (kind == clkcal_pkg::KIND_TICK) begin
         if (run_cfg) begin
            lim = (rate_cfg == 0) ? 1 : rate_cfg;
            nxt = cal.prescale + 1;
            if (nxt >= lim) begin
               cal.prescale = '0;
               stepped = 1'b1;
               s++;
               if (s == 60) begin s = 0; mi++; end
               if (mi == 60) begin mi = 0; h++; end
               if (h == 24) begin h = 0; d++; end
               if ((d == 31 && short_m) || (d == 29 && m == 2 && !leap) ||
                   (d == 30 && m == 2 && leap) || d == 32) begin
                  d = 1;
                  m++;
               end
               if (m == 13) begin m = 1; y++; end
               if (y == 100) y = 0;
            end else begin
               cal.prescale = clkcal_pkg::TPS_W'(nxt);
            end
         end
      end else if (date_edit && col == clkcal_pkg::COL_PAIR2_TENS) begin
         // month tens toggles the same way in both directions
         if (!(d == 31 && m == 1)) begin
            if (m <= 2) m += 10;
            else if (m == 10) m = 1;
            else if (m > 10) m -= 10;
         end
      end else if (date_edit &&
                   (col == clkcal_pkg::COL_PAIR3_TENS || col == clkcal_pkg::COL_PAIR3_ONES) &&
                   m == 2 && d == 29 && leap) begin
         // leap day pins the year
      end else if (kind == clkcal_pkg::KIND_DATE_UP) begin
         case (col)
            clkcal_pkg::COL_PAIR1_TENS: begin
               if (d == 21 && short_m) d = 1;
               else if (d == 20 && m == 2) d = 10;
               else if (d == 21 && m == 2) d = 11;
               else if (d == 19 && m == 2 && !leap) d = 9;
               else if (d > 30) d -= 30;
               else if (d == 30) d = 10;
               else if (d >= 22) d -= 20;
               else d += 10;
            end
            clkcal_pkg::COL_PAIR1_ONES: begin
               if (d == 29 && m == 2 && leap) d = 20;
               else if (d == 28 && m == 2 && !leap) d = 20;
               else if (d == 30 && short_m) begin end
               else if (d == 31) d = 30;
               else if (d == 9) d = 1;
               else if (d % 10 == 9) d -= 9;
               else d++;
            end
            clkcal_pkg::COL_PAIR2_ONES: begin
               if (!(d == 31 && m != 7) && !(m == 1 && d > (leap ? 29 : 28))) begin
                  if (m == 12) m = 10;
                  else if (m == 9) m = 1;
                  else m++;
               end
            end
            clkcal_pkg::COL_PAIR3_TENS: y = (y >= 90) ? y - 90 : y + 10;
            clkcal_pkg::COL_PAIR3_ONES: y = (y % 10 == 9) ? y - 9 : y + 1;
            default: begin end
         endcase
      end else if (kind == clkcal_pkg::KIND_DATE_DOWN) begin
         case (col)
            clkcal_pkg::COL_PAIR1_TENS: begin
               if (d == 1 && (m == 2 || short_m)) d = 21;
               else if (d == 9 && m == 2 && !leap) d = 19;
               else if (d <= 1) d += 30;
               else if (d < 10) d += 20;
               else if (d == 10 && m == 2) d = 20;
               else if (d == 10) d = 30;
               else d -= 10;
            end
            clkcal_pkg::COL_PAIR1_ONES: begin
               if (d == 20 && m == 2 && !leap) d = 28;
               else if (d == 30 && short_m) begin end
               else if (d == 30) d = 31;
               else if (d == 1) d = 9;
               else if (d % 10 == 0) d += 9;
               else d--;
            end
            clkcal_pkg::COL_PAIR2_ONES: begin
               if (!(d == 31 && m != 8) && !(m == 3 && d > (leap ? 29 : 28))) begin
                  if (m == 10) m = 12;
                  else if (m == 1) m = 9;
                  else m--;
               end
            end
            clkcal_pkg::COL_PAIR3_TENS: y = (y < 10) ? y + 90 : y - 10;
            clkcal_pkg::COL_PAIR3_ONES: y = (y % 10 == 0) ? y + 9 : y - 1;
            default: begin end
         endcase
      end else if (kind == clkcal_pkg::KIND_TIME_UP) begin
         case (col)
            clkcal_pkg::COL_PAIR1_TENS: h = (h >= 20) ? h - 20 : (h > 13) ? h - 10 : h + 10;
            clkcal_pkg::COL_PAIR1_ONES: h = (h == 23) ? 20 : (h % 10 == 9) ? h - 9 : h + 1;
            clkcal_pkg::COL_PAIR2_TENS: mi = (mi >= 50) ? mi - 50 : mi + 10;
            clkcal_pkg::COL_PAIR2_ONES: mi = (mi % 10 == 9) ? mi - 9 : mi + 1;
            clkcal_pkg::COL_PAIR3_TENS: s = (s >= 50) ? s - 50 : s + 10;
            clkcal_pkg::COL_PAIR3_ONES: s = (s % 10 == 9) ? s - 9 : s + 1;
            default: begin end
         endcase
      end else if (kind == clkcal_pkg::KIND_TIME_DOWN) begin
         case (col)
            clkcal_pkg::COL_PAIR1_TENS: h = (h < 10) ? h + ((h >= 4) ? 10 : 20) : h - 10;
            clkcal_pkg::COL_PAIR1_ONES: h = (h == 20) ? 23 : (h % 10 == 0) ? h + 9 : h - 1;
            clkcal_pkg::COL_PAIR2_TENS: mi = (mi < 10) ? mi + 50 : mi - 10;
            clkcal_pkg::COL_PAIR2_ONES: mi = (mi % 10 == 0) ? mi + 9 : mi - 1;
            clkcal_pkg::COL_PAIR3_TENS: s = (s < 10) ? s + 50 : s - 10;
            clkcal_pkg::COL_PAIR3_ONES: s = (s % 10 == 0) ? s + 9 : s - 1;
            default: begin end
         endcase
      end
      cal.sec = clkcal_pkg::SEC_W'(s);
      cal.mins = clkcal_pkg::MIN_W'(mi);
      cal.hour = clkcal_pkg::HOUR_W'(h);
      cal.day = clkcal_pkg::DAY_W'(d);
      cal.mon = clkcal_pkg::MONTH_W'(m);
      cal.yr = clkcal_pkg::YEAR_W'(y);
      r.sec = cal.sec; r.mins = cal.mins; r.hour = cal.hour;
      r.day = cal.day; r.mon = cal.mon;   r.yr = cal.yr;
      r.stepped = stepped;
      return r;
   endfunction

   function automatic cal_reading_type reading(int s, int mi, int h, int d, int mo, int y,
                                               logic st);
      cal_reading_type r;
      r.sec = clkcal_pkg::SEC_W'(s);
      r.mins = clkcal_pkg::MIN_W'(mi);
      r.hour = clkcal_pkg::HOUR_W'(h);
      r.day = clkcal_pkg::DAY_W'(d);
      r.mon = clkcal_pkg::MONTH_W'(mo);
      r.yr = clkcal_pkg::YEAR_W'(y);
      r.stepped = st;
      return r;
   endfunction

   function automatic script_row_type beat_row(logic [2:0] k, logic [3:0] c);
      script_row_type r;
      r.op = ROW_BEAT; r.kind = k; r.col = c;
      r.idx = clkcal_pkg::CSR_RUN_ENABLE; r.val = '0; r.want = '0;
      return r;
   endfunction

   function automatic script_row_type checked_row(logic [2:0] k, logic [3:0] c,
                                                  cal_reading_type w);
      script_row_type r;
      r = beat_row(k, c);
      r.op = ROW_CHECKED;
      r.want = w;
      return r;
   endfunction

   function automatic script_row_type csr_row(clkcal_pkg::csr_index_type i, logic [15:0] v);
      script_row_type r;
      r = beat_row(clkcal_pkg::KIND_TICK, COL_NONE);
      r.op = ROW_CSR; r.idx = i; r.val = v;
      return r;
   endfunction

   // Digit of the model field addressed by an edit column
   function automatic int digit_at(logic is_date, logic [3:0] col);
      int v;
      case (col)
         clkcal_pkg::COL_PAIR1_TENS, clkcal_pkg::COL_PAIR1_ONES:
            v = is_date ? cal.day : cal.hour;
         clkcal_pkg::COL_PAIR2_TENS, clkcal_pkg::COL_PAIR2_ONES:
            v = is_date ? cal.mon : cal.mins;
         default:
            v = is_date ? cal.yr  : cal.sec;
      endcase
      if (col == clkcal_pkg::COL_PAIR1_TENS || col == clkcal_pkg::COL_PAIR2_TENS ||
          col == clkcal_pkg::COL_PAIR3_TENS)
         return v / 10;
      return v % 10;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endtask

   // Offer one request beat; returns at the falling edge after acceptance
   task automatic send_item(logic [2:0] kind, logic [3:0] col, logic typed,
                            cal_reading_type want);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, col};
      req_tuser  <= kind;
      beat_has_want = typed;
      beat_want = want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Stop offering and wait for every response to come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (readings_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(clkcal_pkg::csr_index_type idx, logic [15:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Edit one column until its digit matches, with a cap for blocked edits
   task automatic steer_digit(logic [2:0] k, logic [3:0] col, int target);
      for (int n = 0; n < 10 &&
           digit_at(k == clkcal_pkg::KIND_DATE_UP || k == clkcal_pkg::KIND_DATE_DOWN, col)
           != target; n++)
         send_item(k, col, 1'b0, '0);
   endtask

   // ones, tens, ones again: some tens steps depend on the ones digit
   task automatic steer_pair(logic is_date, logic [3:0] tens_col, int target);
      logic [2:0] k;
      for (int pass = 0; pass < 3; pass++) begin
         if (is_date)
            k = $urandom_range(0, 1) ? clkcal_pkg::KIND_DATE_UP : clkcal_pkg::KIND_DATE_DOWN;
         else
            k = $urandom_range(0, 1) ? clkcal_pkg::KIND_TIME_UP : clkcal_pkg::KIND_TIME_DOWN;
         if (pass == 1) steer_digit(k, tens_col, target / 10);
         else steer_digit(k, tens_col + 4'd1, target % 10);
      end
   endtask

   // Model update and response check, both at the rising edge
   always @(posedge clock) begin : track
      cal_reading_type predicted, due;
      if (reset) begin
         run_cfg  = 1'b1;
         rate_cfg = clkcal_pkg::TPS_RESET;
         cal = '0;
         cal.day = clkcal_pkg::DAY_RESET;
         cal.mon = clkcal_pkg::MONTH_RESET;
         readings_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == clkcal_pkg::CSR_RUN_ENABLE) run_cfg = csr_wdata[0];
            else rate_cfg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            predicted = next_reading(req_tuser, req_tdata[3:0]);
            readings_due.push_back(beat_has_want ? beat_want : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               $error("response beat with no reading due");
               mismatches++;
            end else begin
               due = readings_due.pop_front();
               check_field("seconds_now", 8'(due.sec), 8'(rsp_tdata[5:0]));
               check_field("minutes_now", 8'(due.mins), 8'(rsp_tdata[11:6]));
               check_field("hours_now", 8'(due.hour), 8'(rsp_tdata[16:12]));
               check_field("day_now", 8'(due.day), 8'(rsp_tdata[21:17]));
               check_field("month_now", 8'(due.mon), 8'(rsp_tdata[25:22]));
               check_field("year_now", 8'(due.yr), 8'(rsp_tdata[32:26]));
               check_field("second_stepped", 8'(due.stepped), 8'(rsp_tuser[0]));
            end
         end
      end
   end

   // Receiver: short random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int gap;
      logic held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus
   initial begin : stimulus
      cal_reading_type at_reset;
      logic [31:0] r;
      logic [15:0] rate;
      logic hold_done;
      int mo, yr, dd, hr;

      hold_done = 1'b0;
      at_reset = reading(0, 0, 0, 1, 1, 0, 1'b0);

      // opening script
      script.push_back(checked_row(clkcal_pkg::KIND_TICK, COL_NONE, at_reset));
      script.push_back(checked_row(KIND_SPARE_LO, clkcal_pkg::COL_PAIR1_ONES, at_reset));
      script.push_back(checked_row(KIND_SPARE_HI, clkcal_pkg::COL_PAIR3_ONES, at_reset));
      script.push_back(checked_row(clkcal_pkg::KIND_DATE_UP, COL_NONE, at_reset));
      script.push_back(checked_row(clkcal_pkg::KIND_TIME_DOWN, COL_GAP, at_reset));
      // zero rate behaves as one
      script.push_back(csr_row(clkcal_pkg::CSR_TICKS_PER_SEC, 16'd0));
      script.push_back(checked_row(clkcal_pkg::KIND_TICK, COL_NONE,
                                   reading(1, 0, 0, 1, 1, 0, 1'b1)));
      // count left above a lowered rate steps on the next tick
      script.push_back(csr_row(clkcal_pkg::CSR_TICKS_PER_SEC, clkcal_pkg::TPS_RESET));
      script.push_back(beat_row(clkcal_pkg::KIND_TICK, COL_NONE));
      script.push_back(beat_row(clkcal_pkg::KIND_TICK, COL_NONE));
      script.push_back(csr_row(clkcal_pkg::CSR_TICKS_PER_SEC, 16'd2));
      script.push_back(beat_row(clkcal_pkg::KIND_TICK, COL_NONE));
      // paused: ticks ignored, edits still apply
      script.push_back(csr_row(clkcal_pkg::CSR_RUN_ENABLE, 16'd0));
      script.push_back(beat_row(clkcal_pkg::KIND_TICK, COL_NONE));
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_UP, clkcal_pkg::COL_PAIR3_ONES));
      script.push_back(csr_row(clkcal_pkg::CSR_RUN_ENABLE, 16'd1));
      // walk to 23:59:53 on Dec 31 of year 99
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_DOWN, clkcal_pkg::COL_PAIR1_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_DOWN, clkcal_pkg::COL_PAIR1_ONES));
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_DOWN, clkcal_pkg::COL_PAIR2_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_DOWN, clkcal_pkg::COL_PAIR2_ONES));
      script.push_back(beat_row(clkcal_pkg::KIND_TIME_DOWN, clkcal_pkg::COL_PAIR3_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_DATE_UP, clkcal_pkg::COL_PAIR2_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_DATE_UP, clkcal_pkg::COL_PAIR2_ONES));
      script.push_back(beat_row(clkcal_pkg::KIND_DATE_DOWN, clkcal_pkg::COL_PAIR1_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_DATE_DOWN, clkcal_pkg::COL_PAIR3_TENS));
      script.push_back(beat_row(clkcal_pkg::KIND_DATE_DOWN, clkcal_pkg::COL_PAIR3_ONES));
      script.push_back(csr_row(clkcal_pkg::CSR_TICKS_PER_SEC, 16'd1));
      repeat (6) script.push_back(beat_row(clkcal_pkg::KIND_TICK, COL_NONE));
      // full rollover back to the start of year 0
      script.push_back(checked_row(clkcal_pkg::KIND_TICK, COL_NONE,
                                   reading(0, 0, 0, 1, 1, 0, 1'b1)));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         case (script[i].op)
            ROW_CSR:     write_csr(script[i].idx, script[i].val);
            ROW_CHECKED: send_item(script[i].kind, script[i].col, 1'b1, script[i].want);
            default:     send_item(script[i].kind, script[i].col, 1'b0, '0);
         endcase
      end

      // random rounds, each under a fresh register setting
      while (items_sent < ITEM_COUNT) begin
         quiet = (items_sent >= ITEM_COUNT - QUIET_ITEMS);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: rate = 16'd1;
            4:          rate = 16'd2;
            5:          rate = 16'($urandom_range(3, 5));
            6:          rate = 16'd0;
            7:          rate = 16'hFFFF;
            default:    rate = 16'($urandom);
         endcase
         r = $urandom;
         write_csr(clkcal_pkg::CSR_RUN_ENABLE, {r[15:1], 1'($urandom_range(0, 6) != 0)});
         write_csr(clkcal_pkg::CSR_TICKS_PER_SEC, rate);

         // one long receiver stall while beats keep coming
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_req = 1'b1;
            hold_done = 1'b1;
         end

         if ($urandom_range(0, 9) < 7) begin
            // steer toward a month or year end, then tick across it
            mo = $urandom_range(0, 1) ? $urandom_range(1, 12)
                                      : ($urandom_range(0, 1) ? 2 : 12);
            yr = ($urandom_range(0, 2) == 0) ? 99 : $urandom_range(0, 99);
            case ($urandom_range(0, 4))
               0:       dd = 28;
               1:       dd = 29;
               2:       dd = 30;
               3:       dd = 31;
               default: dd = $urandom_range(1, 31);
            endcase
            hr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 23) : 23;
            steer_pair(1'b1, clkcal_pkg::COL_PAIR2_TENS, mo);
            steer_pair(1'b1, clkcal_pkg::COL_PAIR3_TENS, yr);
            steer_pair(1'b1, clkcal_pkg::COL_PAIR1_TENS, dd);
            steer_pair(1'b0, clkcal_pkg::COL_PAIR1_TENS, hr);
            steer_pair(1'b0, clkcal_pkg::COL_PAIR2_TENS, 59);
            steer_pair(1'b0, clkcal_pkg::COL_PAIR3_TENS, $urandom_range(50, 59));
            repeat ($urandom_range(8, 60)) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(3'($urandom_range(clkcal_pkg::KIND_DATE_UP,
                                              clkcal_pkg::KIND_TIME_DOWN)),
                            edit_cols[$urandom_range(0, 5)], 1'b0, '0);
               else
                  send_item(clkcal_pkg::KIND_TICK, COL_NONE, 1'b0, '0);
            end
         end else begin
            // noise: any kind, any column
            repeat ($urandom_range(10, 30))
               send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 1'b0, '0);
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/clkcal_pkg.sv
hw/rtl/clock_calendar_with_digit_edit_core.sv
bench/clock_calendar_with_digit_edit_core_test.sv
